### rtl/mdp_pkg.sv
// ----------------------------------------------------------------------------
// mdp_pkg
// Shared types and constants of the decimal format printer.
// ----------------------------------------------------------------------------
package mdp_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned ArgW          = 32;
  localparam int unsigned OutCountW     = 16;
  localparam int unsigned DigitsN       = 10;
  localparam int unsigned BcdW          = 4 * DigitsN;
  localparam int unsigned IterW         = $clog2(ArgW);
  localparam int unsigned IdxW          = $clog2(DigitsN);
  localparam int unsigned InDataW       = ByteW + ArgW;
  localparam int unsigned OutDataW      = ByteW + OutCountW;

  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] ChLowerD  = 8'h64;
  localparam logic [ByteW-1:0] ChMinus   = 8'h2d;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StConv,
    StSign,
    StSkip,
    StDigit
  } state_e;

  typedef enum logic [1:0] {
    SelByte,
    SelPercent,
    SelMinus,
    SelDigit
  } char_sel_e;

  typedef struct packed {
    logic      load_in;
    logic      apply_restart;
    logic      set_pending;
    logic      clr_pending;
    logic      conv_start;
    logic      conv_step;
    logic      digit_shift;
    logic      emit;
    logic      emit_last;
    char_sel_e char_sel;
  } cmd_t;

  typedef struct packed {
    logic is_percent;
    logic is_d;
    logic pending;
    logic restart;
    logic neg;
    logic iter_last;
    logic top_zero;
    logic idx_zero;
    logic out_free;
  } status_t;

endpackage

### rtl/mdp_datapath.sv
// ----------------------------------------------------------------------------
// mdp_datapath
// Input word latch, state, binary-to-BCD shifter, digit walker and
// output register of the decimal format printer.
// ----------------------------------------------------------------------------
module mdp_datapath #(
  parameter int unsigned COUNT_WIDTH = mdp_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mdp_pkg::cmd_t                 cmd_i,
  output mdp_pkg::status_t              status_o,
  input  logic [mdp_pkg::InDataW-1:0]   in_data_i,
  input  logic                          in_restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mdp_pkg::OutDataW-1:0]  out_data_o,
  output logic                          out_last_o
);
  import mdp_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [ByteW-1:0]       byte_q;
  logic [ArgW-1:0]        arg_q;
  logic                   restart_q;
  logic                   pending_q, pending_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d, count_base, count_inc;
  logic                   neg_q;
  logic [ArgW-1:0]        mag_q;
  logic [BcdW-1:0]        bcd_q;
  logic [BcdW-1:0]        bcd_adj;
  logic [IterW-1:0]       iter_q;
  logic [IdxW-1:0]        idx_q;
  logic [ByteW-1:0]       out_char_q, char_d;
  logic [OutCountW-1:0]   out_cnt_q;
  logic                   out_last_q;
  logic                   out_valid_q;
  logic                   out_free;
  logic                   clear_now;
  logic [COUNT_WIDTH+OutCountW-1:0] count_wide;

  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] v);
    logic [BcdW-1:0] r;
    r = v;
    for (int i = 0; i < DigitsN; i++) begin
      if (v[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = v[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign out_free  = !out_valid_q || out_ready_i;
  assign clear_now = cmd_i.apply_restart && restart_q;
  assign bcd_adj   = bcd_adjust(bcd_q);

  assign status_o.is_percent = (byte_q == ChPercent);
  assign status_o.is_d       = (byte_q == ChLowerD);
  assign status_o.pending    = pending_q;
  assign status_o.restart    = restart_q;
  assign status_o.neg        = neg_q;
  assign status_o.iter_last  = (iter_q == IterW'(ArgW - 1));
  assign status_o.top_zero   = (bcd_q[BcdW-1 -: 4] == 4'd0);
  assign status_o.idx_zero   = (idx_q == '0);
  assign status_o.out_free   = out_free;

  always_comb begin
    pending_d = pending_q;
    if (clear_now) begin
      pending_d = 1'b0;
    end
    if (cmd_i.set_pending) begin
      pending_d = 1'b1;
    end else if (cmd_i.clr_pending) begin
      pending_d = 1'b0;
    end
  end

  always_comb begin
    count_base = clear_now ? '0 : count_q;
    count_inc  = (count_base != CountMax) ? count_base + 1'b1 : count_base;
    count_d    = cmd_i.emit ? count_inc : count_base;
    count_wide = {{OutCountW{1'b0}}, count_inc};
  end

  always_comb begin
    unique case (cmd_i.char_sel)
      SelByte:    char_d = byte_q;
      SelPercent: char_d = ChPercent;
      SelMinus:   char_d = ChMinus;
      SelDigit:   char_d = ChZero + {4'd0, bcd_q[BcdW-1 -: 4]};
      default:    char_d = byte_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      byte_q    <= in_data_i[ByteW-1:0];
      arg_q     <= in_data_i[InDataW-1:ByteW];
      restart_q <= in_restart_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      count_q   <= '0;
    end else begin
      pending_q <= pending_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.conv_start) begin
        iter_q <= '0;
        idx_q  <= IdxW'(DigitsN - 1);
      end else begin
        if (cmd_i.conv_step) begin
          iter_q <= iter_q + 1'b1;
        end
        if (cmd_i.digit_shift && idx_q != '0) begin
          idx_q <= idx_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_start) begin
      neg_q <= arg_q[ArgW-1];
      mag_q <= arg_q[ArgW-1] ? (~arg_q + 1'b1) : arg_q;
      bcd_q <= '0;
    end else if (cmd_i.conv_step) begin
      mag_q <= {mag_q[ArgW-2:0], 1'b0};
      bcd_q <= {bcd_adj[BcdW-2:0], mag_q[ArgW-1]};
    end else if (cmd_i.digit_shift) begin
      bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= char_d;
      out_cnt_q  <= count_wide[OutCountW-1:0];
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_cnt_q, out_char_q};
  assign out_last_o  = out_last_q;

endmodule

### rtl/mdp_ctrl.sv
// ----------------------------------------------------------------------------
// mdp_ctrl
// Sequencer of the decimal format printer: decodes the format word and
// steps the conversion and digit output.
// ----------------------------------------------------------------------------
module mdp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mdp_pkg::status_t status_i,
  output mdp_pkg::cmd_t    cmd_o
);
  import mdp_pkg::*;

  state_e state_q, state_d;
  logic   eff_pending;

  assign eff_pending = status_i.pending && !status_i.restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.apply_restart = 1'b1;
        priority if (eff_pending) begin
          priority if (status_i.is_percent) begin
            if (status_i.out_free) begin
              cmd_o.clr_pending = 1'b1;
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.char_sel    = SelPercent;
              state_d           = StIdle;
            end
          end else if (status_i.is_d) begin
            cmd_o.clr_pending = 1'b1;
            cmd_o.conv_start  = 1'b1;
            state_d           = StConv;
          end else begin
            cmd_o.clr_pending = 1'b1;
            state_d           = StIdle;
          end
        end else if (status_i.is_percent) begin
          cmd_o.set_pending = 1'b1;
          state_d           = StIdle;
        end else begin
          if (status_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            cmd_o.char_sel  = SelByte;
            state_d         = StIdle;
          end
        end
      end
      StConv: begin
        cmd_o.conv_step = 1'b1;
        if (status_i.iter_last) begin
          state_d = StSign;
        end
      end
      StSign: begin
        if (!status_i.neg) begin
          state_d = StSkip;
        end else if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.char_sel = SelMinus;
          state_d        = StSkip;
        end
      end
      StSkip: begin
        if (status_i.top_zero && !status_i.idx_zero) begin
          cmd_o.digit_shift = 1'b1;
        end else begin
          state_d = StDigit;
        end
      end
      StDigit: begin
        if (status_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = status_i.idx_zero;
          cmd_o.char_sel    = SelDigit;
          cmd_o.digit_shift = 1'b1;
          if (status_i.idx_zero) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

### rtl/mini_format_decimal_printer_top.sv
// ----------------------------------------------------------------------------
// mini_format_decimal_printer_top
// Format printer for plain text, %% and %d with a signed 32-bit argument.
// ----------------------------------------------------------------------------
// Takes one format byte per input word and emits zero or more characters.
// An ordinary byte, or the second byte of %%, is accepted and decoded and
// its character loaded into the output register; a lone % emits nothing.
// A %d runs through accept and decode, a 32-step binary-to-BCD shifter (one
// bit a cycle), a sign step emitting a minus for a negative argument, a skip
// of leading zero positions, the entry to the digit output and one output
// step per remaining digit; an output stall holds the emitting step. The
// input is taken again in the cycle after the last character is loaded into
// the output register, so an item is accepted while its predecessor's final
// character still waits. Each character carries the running count since the
// last restart, saturating at 2^COUNT_WIDTH-1; tlast marks a word's final character.
module mini_format_decimal_printer_top #(
  parameter int unsigned COUNT_WIDTH = mdp_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] format_byte, [39:8] int_arg
  input  logic [mdp_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] restart
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_char, [23:8] char_count
  output logic [mdp_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);
  import mdp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mdp_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_data_i    (s_axis_tdata),
    .in_restart_i (s_axis_tuser[0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
